// ===== rtl/pspc_pkg.sv =====
package pspc_pkg;

	localparam int ADC_BITS     = 12;
	localparam int AVG_TAPS_DEF = 5;
	localparam int NUM_W        = 48;
	localparam int DEN_W        = 32;
	localparam int SMP_W        = 16;
	localparam int CFG_W        = 16;
	localparam int THR_W        = 15;
	localparam int DC_W         = 15;
	localparam int S_W          = ADC_BITS + 2;
	localparam int T_W          = ADC_BITS + 1;
	localparam int SQRT_IN_W    = 64;
	localparam int SQRT_OUT_W   = 32;
	localparam int BASE_W       = 33;
	localparam int EXTRA_W      = 24;

	localparam longint ADC_FULL  = longint'(1) << ADC_BITS;
	localparam longint SMP_BIAS  = 32768;
	localparam longint AC_MUL_L  = 291456000;
	localparam longint AC_DEN_L  = 20000 * ADC_FULL;
	localparam longint AC_OFF_L  = AC_DEN_L * SMP_BIAS - 438932736 * ADC_FULL
		+ 10000 * ADC_FULL;
	localparam longint DC_MUL_L  = 3113472;
	localparam longint DC_DEN_L  = 200 * ADC_FULL;
	localparam longint DC_OFF_L  = 7680 * ADC_FULL + 100 * ADC_FULL;

	localparam logic [NUM_W-1:0] AC_MUL = NUM_W'(AC_MUL_L);
	localparam logic [NUM_W-1:0] AC_OFF = NUM_W'(AC_OFF_L);
	localparam logic [NUM_W-1:0] DC_MUL = NUM_W'(DC_MUL_L);
	localparam logic [NUM_W-1:0] DC_OFF = NUM_W'(DC_OFF_L);

	// The sample divisors are a power of two times an odd constant; the odd part is
	// removed by a reciprocal multiplication that is exact over the operand range.
	localparam int     RCP_SH    = 36;
	localparam int     AC_SH     = ADC_BITS + 5;
	localparam int     DC_SH     = ADC_BITS + 3;
	localparam int     AC_Y_W    = 26;
	localparam int     DC_Y_W    = 20;
	localparam int     AC_RCP_W  = 27;
	localparam int     DC_RCP_W  = 32;
	localparam int     AC_PROD_W = AC_Y_W + AC_RCP_W;
	localparam int     DC_PROD_W = DC_Y_W + DC_RCP_W;
	localparam longint AC_ODD    = AC_DEN_L >> AC_SH;
	localparam longint DC_ODD    = DC_DEN_L >> DC_SH;
	localparam logic [AC_RCP_W-1:0] AC_RCP =
		AC_RCP_W'(((longint'(1) << RCP_SH) + AC_ODD - 1) / AC_ODD);
	localparam logic [DC_RCP_W-1:0] DC_RCP =
		DC_RCP_W'(((longint'(1) << RCP_SH) + DC_ODD - 1) / DC_ODD);

	localparam int AVG_NUM_W  = 24;
	localparam int AVG_RCP_W  = 32;
	localparam int AVG_RCP_SH = 32;
	localparam int AVG_PROD_W = AVG_NUM_W + AVG_RCP_W;

	localparam logic [CFG_W-1:0] RST_CMP  = 16'd1000;
	localparam logic [CFG_W-1:0] RST_PMAX = 16'd50000;
	localparam logic [CFG_W-1:0] RST_PMIN = 16'd1200;
	localparam logic [THR_W-1:0] RST_THR  = 15'd640;
	localparam logic [CFG_W-1:0] RST_GAIN = 16'd2240;

	localparam logic [1:0] POL_OFF = 2'd0;
	localparam logic [1:0] POL_POS = 2'd1;
	localparam logic [1:0] POL_NEG = 2'd2;

	typedef enum logic [2:0] {
		REG_CMP  = 3'd0,
		REG_PMAX = 3'd1,
		REG_PMIN = 3'd2,
		REG_THR  = 3'd3,
		REG_GAIN = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		DOP_BASE,
		DOP_EXTRA
	} div_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL1,
		ST_SMP_RCP,
		ST_SMP,
		ST_HIST,
		ST_AVG_RCP,
		ST_AVG,
		ST_CLASS,
		ST_MUL2,
		ST_BASE_LE,
		ST_BASE_GO,
		ST_BASE_WAIT,
		ST_MUL3,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_EXT_GO,
		ST_EXT_WAIT,
		ST_CLAMP,
		ST_FINISH
	} st_t;

	typedef struct packed {
		logic    load;
		logic    mul1;
		logic    smp_rcp;
		logic    smp;
		logic    avg_rcp;
		logic    avg;
		logic    div_start;
		logic    div_wait;
		div_op_t div_op;
		logic    hist;
		logic    classify;
		logic    mul2;
		logic    base_le;
		logic    mul3;
		logic    sqrt_start;
		logic    sqrt_wait;
		logic    clamp;
		logic    finish;
	} pspc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic le;
		logic ext;
	} pspc_stat_t;

endpackage

// ===== rtl/pspc_div.sv =====
module pspc_div
	import pspc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== rtl/pspc_sqrt.sv =====
module pspc_sqrt
	import pspc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQRT_IN_W-1:0]  rad,
	output logic                  done,
	output logic [SQRT_OUT_W-1:0] root
);

	localparam int CNT_W = $clog2(SQRT_OUT_W + 1);
	localparam int REM_W = SQRT_OUT_W + 3;

	logic [SQRT_IN_W-1:0]  rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [SQRT_OUT_W-1:0] root_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [REM_W+1:0]      rem_sh;
	logic [REM_W+1:0]      trial;
	logic                  ge;

	assign rem_sh = {rem_q, rad_q[SQRT_IN_W-1 -: 2]};
	assign trial  = {3'b000, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SQRT_OUT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQRT_IN_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			root_q <= {root_q[SQRT_OUT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/pspc_datapath.sv =====
module pspc_datapath
	import pspc_pkg::*;
#(
	parameter int AVG_TAPS = AVG_TAPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pspc_cmd_t               cmd,
	output pspc_stat_t              stat,
	input  logic [11:0]             ac_code_a,
	input  logic [11:0]             ac_code_b,
	input  logic [11:0]             ac_code_c,
	input  logic [11:0]             dc_code_a,
	input  logic [11:0]             dc_code_b,
	input  logic [CFG_W-1:0]        compare_value,
	input  logic [CFG_W-1:0]        period_max,
	input  logic [CFG_W-1:0]        period_min,
	input  logic [THR_W-1:0]        polarity_threshold,
	input  logic [CFG_W-1:0]        extra_time_gain,
	output logic signed [SMP_W-1:0] ac_volts_avg,
	output logic [DC_W-1:0]         dc_volts_avg,
	output logic [1:0]              polarity,
	output logic [CFG_W-1:0]        switch_period,
	output logic                    deadband_on
);

	localparam int HIST_LEN = AVG_TAPS - 1;
	localparam int SUM_W    = SMP_W + 1 + $clog2(AVG_TAPS);
	localparam int AVG_DIV  = 2 * AVG_TAPS;
	localparam logic [AVG_RCP_W-1:0] AVG_RCP =
		AVG_RCP_W'(((longint'(1) << AVG_RCP_SH) + AVG_DIV - 1) / AVG_DIV);

	logic [S_W-1:0]          s_q;
	logic [T_W-1:0]          t_q;
	logic [NUM_W-1:0]        ac_prod_q;
	logic [NUM_W-1:0]        dc_prod_q;
	logic [AC_PROD_W-1:0]    ac_rcp_q;
	logic [DC_PROD_W-1:0]    dc_rcp_q;
	logic [AVG_PROD_W-1:0]   ac_avg_rcp_q;
	logic [AVG_PROD_W-1:0]   dc_avg_rcp_q;
	logic signed [SMP_W-1:0] ac_smp_q;
	logic signed [SMP_W-1:0] dc_smp_q;
	logic signed [SMP_W-1:0] ac_hist_q [HIST_LEN];
	logic signed [SMP_W-1:0] dc_hist_q [HIST_LEN];
	logic signed [SUM_W-1:0] ac_hsum_q;
	logic signed [SUM_W-1:0] dc_hsum_q;
	logic signed [SUM_W-1:0] ac_tot_q;
	logic signed [SUM_W-1:0] dc_tot_q;
	logic signed [SMP_W-1:0] ac_avg_q;
	logic [DC_W-1:0]         dc_avg_q;
	logic [1:0]              pol_q;
	logic [SMP_W-1:0]        v_q;
	logic [DC_W-1:0]         d_q;
	logic                    le_q;
	logic                    ext_q;
	logic [31:0]             vc_q;
	logic [30:0]             p_q;
	logic [31:0]             g2_q;
	logic [BASE_W-1:0]       base_q;
	logic [SQRT_IN_W-1:0]    x_q;
	logic [EXTRA_W-1:0]      extra_q;
	logic [CFG_W-1:0]        clamp_q;

	logic [NUM_W-1:0]            div_num;
	logic [DEN_W-1:0]            div_den;
	logic                        div_done;
	logic [NUM_W-1:0]            div_quot;
	logic                        sqrt_done;
	logic [SQRT_OUT_W-1:0]       sqrt_root;
	logic [AC_Y_W-1:0]           ac_y;
	logic [DC_Y_W-1:0]           dc_y;
	logic signed [AVG_NUM_W-1:0] ac_avg_num;
	logic signed [AVG_NUM_W-1:0] dc_avg_num;
	logic signed [SMP_W:0]       avg_ext;
	logic signed [SMP_W:0]       thr_ext;
	logic [SMP_W-1:0]            v_next;
	logic [1:0]                  pol_next;
	logic [SMP_W:0]              twov;
	logic                        le_next;
	logic [SMP_W-1:0]            pfac;
	logic [EXTRA_W:0]            psum;

	assign ac_y       = ac_prod_q[AC_SH +: AC_Y_W];
	assign dc_y       = dc_prod_q[DC_SH +: DC_Y_W];
	assign ac_avg_num = (AVG_NUM_W'(ac_tot_q) <<< 1) + AVG_NUM_W'(AVG_TAPS * 65537);
	assign dc_avg_num = (AVG_NUM_W'(dc_tot_q) <<< 1) + AVG_NUM_W'(AVG_TAPS);

	always_comb begin
		div_num = NUM_W'(vc_q);
		div_den = DEN_W'(d_q);
		case (cmd.div_op)
			DOP_BASE: begin
				div_num = NUM_W'(vc_q);
				div_den = DEN_W'(d_q);
			end
			DOP_EXTRA: begin
				div_num = NUM_W'(sqrt_root[SQRT_OUT_W-1:8]);
				div_den = DEN_W'(d_q);
			end
			default: begin
				div_num = NUM_W'(vc_q);
				div_den = DEN_W'(d_q);
			end
		endcase
	end

	pspc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	pspc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (x_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign avg_ext = (SMP_W + 1)'(ac_avg_q);
	assign thr_ext = signed'({2'b00, polarity_threshold});

	always_comb begin
		if (avg_ext > thr_ext) begin
			pol_next = POL_POS;
			v_next   = ac_avg_q;
		end else if (avg_ext < -thr_ext) begin
			pol_next = POL_NEG;
			v_next   = SMP_W'(-avg_ext);
		end else begin
			pol_next = POL_OFF;
			v_next   = '0;
		end
	end

	assign le_next = SMP_W'(dc_avg_q) <= v_next;
	assign twov    = {v_q, 1'b0};
	assign pfac    = SMP_W'(twov - (SMP_W + 1)'(dc_avg_q));
	assign psum    = (EXTRA_W + 1)'(clamp_q) + (EXTRA_W + 1)'(extra_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_hsum_q <= '0;
			dc_hsum_q <= '0;
			for (int i = 0; i < HIST_LEN; i++) begin
				ac_hist_q[i] <= '0;
				dc_hist_q[i] <= '0;
			end
		end else if (cmd.hist) begin
			ac_hsum_q <= ac_hsum_q + SUM_W'(ac_smp_q) - SUM_W'(ac_hist_q[0]);
			dc_hsum_q <= dc_hsum_q + SUM_W'(dc_smp_q) - SUM_W'(dc_hist_q[0]);
			for (int i = 0; i < HIST_LEN - 1; i++) begin
				ac_hist_q[i] <= ac_hist_q[i+1];
				dc_hist_q[i] <= dc_hist_q[i+1];
			end
			ac_hist_q[HIST_LEN-1] <= ac_smp_q;
			dc_hist_q[HIST_LEN-1] <= dc_smp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q <= S_W'(ac_code_a) + S_W'(ac_code_b) + S_W'(ac_code_c);
			t_q <= T_W'(dc_code_a) + T_W'(dc_code_b);
		end
		if (cmd.mul1) begin
			ac_prod_q <= NUM_W'(s_q) * AC_MUL + AC_OFF;
			dc_prod_q <= NUM_W'(t_q) * DC_MUL + DC_OFF;
		end
		if (cmd.smp_rcp) begin
			ac_rcp_q <= AC_PROD_W'(ac_y) * AC_PROD_W'(AC_RCP);
			dc_rcp_q <= DC_PROD_W'(dc_y) * DC_PROD_W'(DC_RCP);
		end
		if (cmd.smp) begin
			ac_smp_q <= signed'(ac_rcp_q[RCP_SH +: SMP_W] ^ 16'h8000);
			dc_smp_q <= signed'(dc_rcp_q[RCP_SH +: SMP_W]);
		end
		if (cmd.avg_rcp) begin
			ac_avg_rcp_q <= AVG_PROD_W'(unsigned'(ac_avg_num)) * AVG_PROD_W'(AVG_RCP);
			dc_avg_rcp_q <= AVG_PROD_W'(unsigned'(dc_avg_num)) * AVG_PROD_W'(AVG_RCP);
		end
		if (cmd.avg) begin
			ac_avg_q <= signed'(ac_avg_rcp_q[AVG_RCP_SH +: SMP_W] ^ 16'h8000);
			dc_avg_q <= dc_avg_rcp_q[AVG_RCP_SH +: DC_W];
		end
		if (cmd.div_wait && div_done) begin
			case (cmd.div_op)
				DOP_BASE:   base_q <= BASE_W'(compare_value) + BASE_W'(div_quot[31:0]);
				DOP_EXTRA:  extra_q <= div_quot[EXTRA_W-1:0];
				default:    extra_q <= extra_q;
			endcase
		end
		if (cmd.hist) begin
			ac_tot_q <= ac_hsum_q + SUM_W'(ac_smp_q);
			dc_tot_q <= dc_hsum_q + SUM_W'(dc_smp_q);
		end
		if (cmd.classify) begin
			pol_q   <= pol_next;
			v_q     <= v_next;
			le_q    <= le_next;
			ext_q   <= !le_next && ((SMP_W + 1)'(dc_avg_q) <= {v_next, 1'b0});
			d_q     <= dc_avg_q - v_next[DC_W-1:0];
			extra_q <= '0;
		end
		if (cmd.mul2) begin
			vc_q <= 32'(v_q) * 32'(compare_value);
			p_q  <= 31'(pfac) * 31'(dc_avg_q);
			g2_q <= 32'(extra_time_gain) * 32'(extra_time_gain);
		end
		if (cmd.base_le) begin
			base_q <= BASE_W'(compare_value) + BASE_W'(vc_q[31:6]);
		end
		if (cmd.mul3) begin
			x_q <= SQRT_IN_W'(g2_q) * SQRT_IN_W'(p_q);
		end
		if (cmd.clamp) begin
			if (base_q > BASE_W'(period_max)) begin
				clamp_q <= period_max;
			end else if (base_q < BASE_W'(period_min)) begin
				clamp_q <= period_min;
			end else begin
				clamp_q <= base_q[CFG_W-1:0];
			end
		end
		if (cmd.finish) begin
			ac_volts_avg  <= ac_avg_q;
			dc_volts_avg  <= dc_avg_q;
			polarity      <= pol_q;
			deadband_on   <= pol_q != POL_OFF;
			switch_period <= (psum > (EXTRA_W + 1)'(16'hFFFF)) ? 16'hFFFF
				: psum[CFG_W-1:0];
		end
	end

	assign stat.div_done  = div_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.le        = le_q;
	assign stat.ext       = ext_q;

endmodule

// ===== rtl/pspc_ctrl.sv =====
module pspc_ctrl
	import pspc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  pspc_stat_t stat,
	output pspc_cmd_t  cmd
);

	st_t  state_q;
	st_t  state_next;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_next = ST_MUL1;
			ST_MUL1:      state_next = ST_SMP_RCP;
			ST_SMP_RCP:   state_next = ST_SMP;
			ST_SMP:       state_next = ST_HIST;
			ST_HIST:      state_next = ST_AVG_RCP;
			ST_AVG_RCP:   state_next = ST_AVG;
			ST_AVG:       state_next = ST_CLASS;
			ST_CLASS:     state_next = ST_MUL2;
			ST_MUL2:      state_next = stat.le ? ST_BASE_LE : ST_BASE_GO;
			ST_BASE_LE:   state_next = ST_CLAMP;
			ST_BASE_GO:   state_next = ST_BASE_WAIT;
			ST_BASE_WAIT: if (stat.div_done) state_next = stat.ext ? ST_MUL3 : ST_CLAMP;
			ST_MUL3:      state_next = ST_SQRT_GO;
			ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
			ST_SQRT_WAIT: if (stat.sqrt_done) state_next = ST_EXT_GO;
			ST_EXT_GO:    state_next = ST_EXT_WAIT;
			ST_EXT_WAIT:  if (stat.div_done) state_next = ST_CLAMP;
			ST_CLAMP:     state_next = ST_FINISH;
			ST_FINISH:    if (out_free) state_next = ST_IDLE;
			default:      state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.div_op     = DOP_BASE;
		unique case (state_q)
			ST_IDLE:      cmd.load = in_valid;
			ST_MUL1:      cmd.mul1 = 1'b1;
			ST_SMP_RCP:   cmd.smp_rcp = 1'b1;
			ST_SMP:       cmd.smp = 1'b1;
			ST_HIST:      cmd.hist = 1'b1;
			ST_AVG_RCP:   cmd.avg_rcp = 1'b1;
			ST_AVG:       cmd.avg = 1'b1;
			ST_CLASS:     cmd.classify = 1'b1;
			ST_MUL2:      cmd.mul2 = 1'b1;
			ST_BASE_LE:   cmd.base_le = 1'b1;
			ST_BASE_GO: begin
				cmd.div_op    = DOP_BASE;
				cmd.div_start = 1'b1;
			end
			ST_BASE_WAIT: begin
				cmd.div_op   = DOP_BASE;
				cmd.div_wait = 1'b1;
			end
			ST_MUL3:      cmd.mul3 = 1'b1;
			ST_SQRT_GO:   cmd.sqrt_start = 1'b1;
			ST_SQRT_WAIT: cmd.sqrt_wait = 1'b1;
			ST_EXT_GO: begin
				cmd.div_op    = DOP_EXTRA;
				cmd.div_start = 1'b1;
			end
			ST_EXT_WAIT: begin
				cmd.div_op   = DOP_EXTRA;
				cmd.div_wait = 1'b1;
			end
			ST_CLAMP:     cmd.clamp = 1'b1;
			ST_FINISH:    cmd.finish = out_free;
			default:      cmd.div_op = DOP_BASE;
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/pfc_switching_period_calc.sv =====
// The result comes without a division when the DC voltage does not exceed the rectified AC
// voltage, after one division when the base period needs one, and after the square root and
// a second division when the square-root term is added; one item is processed at a time and
// the next transfer is taken only after the result is written, so an output stall holds it up.
// The divider is shared by both divisions and the square root runs in its own unit.
// Reset clears the controller, histories and running sums and loads the default registers.
module pfc_switching_period_calc
	import pspc_pkg::*;
#(
	parameter int AVG_TAPS = AVG_TAPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [11:0]             ac_code_a,
	input  logic [11:0]             ac_code_b,
	input  logic [11:0]             ac_code_c,
	input  logic [11:0]             dc_code_a,
	input  logic [11:0]             dc_code_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] ac_volts_avg,
	output logic [DC_W-1:0]         dc_volts_avg,
	output logic [1:0]              polarity,
	output logic [CFG_W-1:0]        switch_period,
	output logic                    deadband_on
);

	logic [CFG_W-1:0] cmp_q;
	logic [CFG_W-1:0] pmax_q;
	logic [CFG_W-1:0] pmin_q;
	logic [THR_W-1:0] thr_q;
	logic [CFG_W-1:0] gain_q;
	logic             wr_en;
	cfg_reg_t         reg_idx;
	pspc_cmd_t        cmd;
	pspc_stat_t       stat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = cfg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q  <= RST_CMP;
			pmax_q <= RST_PMAX;
			pmin_q <= RST_PMIN;
			thr_q  <= RST_THR;
			gain_q <= RST_GAIN;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CMP:  cmp_q  <= pwdata[CFG_W-1:0];
				REG_PMAX: pmax_q <= pwdata[CFG_W-1:0];
				REG_PMIN: pmin_q <= pwdata[CFG_W-1:0];
				REG_THR:  thr_q  <= pwdata[THR_W-1:0];
				REG_GAIN: gain_q <= pwdata[CFG_W-1:0];
				default:  cmp_q  <= cmp_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CMP:  prdata = 32'(cmp_q);
			REG_PMAX: prdata = 32'(pmax_q);
			REG_PMIN: prdata = 32'(pmin_q);
			REG_THR:  prdata = 32'(thr_q);
			REG_GAIN: prdata = 32'(gain_q);
			default:  prdata = '0;
		endcase
	end

	pspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pspc_datapath #(
		.AVG_TAPS (AVG_TAPS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.ac_code_a          (ac_code_a),
		.ac_code_b          (ac_code_b),
		.ac_code_c          (ac_code_c),
		.dc_code_a          (dc_code_a),
		.dc_code_b          (dc_code_b),
		.compare_value      (cmp_q),
		.period_max         (pmax_q),
		.period_min         (pmin_q),
		.polarity_threshold (thr_q),
		.extra_time_gain    (gain_q),
		.ac_volts_avg       (ac_volts_avg),
		.dc_volts_avg       (dc_volts_avg),
		.polarity           (polarity),
		.switch_period      (switch_period),
		.deadband_on        (deadband_on)
	);

	// The dead band follows the polarity of every delivered result.
	a_deadband: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (deadband_on == (polarity != POL_OFF)))
		else $error("deadband_on disagrees with polarity");

	// No new item is taken in the cycle after a transfer on the input.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in progress");

	// With ordered clamps the period never falls below the lower clamp.
	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (pmin_q <= pmax_q)) |-> (switch_period >= pmin_q))
		else $error("switch_period below period_min");

	// The three-valued polarity code never takes its unused value.
	a_pol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (polarity == POL_OFF || polarity == POL_POS || polarity == POL_NEG))
		else $error("polarity out of range");

endmodule

// ===== verif/tb_pfc_switching_period_calc.sv =====
`timescale 1ns / 1ps

module tb_pfc_switching_period_calc;
	import pspc_pkg::*;

	typedef struct {
		logic [11:0] ac_a;
		logic [11:0] ac_b;
		logic [11:0] ac_c;
		logic [11:0] dc_a;
		logic [11:0] dc_b;
	} adc_seq_t;

	typedef struct {
		logic [15:0] ac_avg;
		logic [14:0] dc_avg;
		logic [1:0]  pol;
		logic [15:0] period;
		logic        db_on;
	} period_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [11:0] ac_code_a = '0;
	logic [11:0] ac_code_b = '0;
	logic [11:0] ac_code_c = '0;
	logic [11:0] dc_code_a = '0;
	logic [11:0] dc_code_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] ac_volts_avg;
	logic [14:0] dc_volts_avg;
	logic [1:0] polarity;
	logic [15:0] switch_period;
	logic deadband_on;

	adc_seq_t seq_pending[$];
	period_result_t period_expected[$];
	int fail_count = 0;
	bit sender_quiet = 1'b0;
	bit sink_quiet = 1'b0;

	longint unsigned cmp_mirror = 1000;
	longint unsigned pmax_mirror = 50000;
	longint unsigned pmin_mirror = 1200;
	longint unsigned thr_mirror = 640;
	longint unsigned gain_mirror = 2240;
	longint ac_hist[4] = '{0, 0, 0, 0};
	longint dc_hist[4] = '{0, 0, 0, 0};

	pfc_switching_period_calc u_dut (.*);

	always #10 clk = ~clk;

	function automatic longint div_floor(longint n, longint d);
		if (n >= 0)
			return n / d;
		return -(((-n) + d - 1) / d);
	endfunction

	function automatic longint div_round(longint n, longint d);
		return div_floor(2 * n + d, 2 * d);
	endfunction

	function automatic longint unsigned sqrt_floor(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic period_result_t predict_period(adc_seq_t it);
		period_result_t res;
		longint s, t, acs, dcs, aca, dca, v, u, sum_a, sum_d;
		longint unsigned base, extra, per, d, p;
		s = longint'(it.ac_a) + longint'(it.ac_b) + longint'(it.ac_c);
		t = longint'(it.dc_a) + longint'(it.dc_b);
		acs = div_round(s * 145728000 - 219466368 * 4096, 10000 * 4096);
		dcs = div_round(t * 1556736 + 3840 * 4096, 100 * 4096);
		sum_a = acs;
		sum_d = dcs;
		for (int i = 0; i < 4; i++) begin
			sum_a += ac_hist[i];
			sum_d += dc_hist[i];
		end
		for (int i = 0; i < 3; i++) begin
			ac_hist[i] = ac_hist[i+1];
			dc_hist[i] = dc_hist[i+1];
		end
		ac_hist[3] = acs;
		dc_hist[3] = dcs;
		aca = div_round(sum_a, 5);
		dca = div_round(sum_d, 5);
		if (aca > longint'(thr_mirror)) begin
			res.pol = POL_POS;
			v = aca;
		end else if (aca < -longint'(thr_mirror)) begin
			res.pol = POL_NEG;
			v = -aca;
		end else begin
			res.pol = POL_OFF;
			v = 0;
		end
		u = dca;
		extra = 0;
		if (u <= v) begin
			base = cmp_mirror + (longint'(v) * cmp_mirror) / 64;
		end else begin
			d = u - v;
			base = cmp_mirror + (longint'(v) * cmp_mirror) / d;
			if (u <= 2 * v) begin
				p = longint'(2 * v - u) * longint'(u);
				extra = sqrt_floor(gain_mirror * gain_mirror * p) / (256 * d);
			end
		end
		if (base > pmax_mirror)
			base = pmax_mirror;
		else if (base < pmin_mirror)
			base = pmin_mirror;
		per = base + extra;
		if (per > 65535)
			per = 65535;
		res.ac_avg = aca[15:0];
		res.dc_avg = dca[14:0];
		res.period = per[15:0];
		res.db_on = (res.pol != POL_OFF);
		return res;
	endfunction

	function automatic int pick_gap();
		if (sender_quiet || $urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(30, 300);
		return $urandom_range(1, 5);
	endfunction

	int send_gap = 0;
	always @(posedge clk) begin
		adc_seq_t nx;
		if (in_valid && !in_stall)
			period_expected.push_back(predict_period('{ac_code_a, ac_code_b, ac_code_c,
				dc_code_a, dc_code_b}));
		if (!(in_valid && in_stall) && arst_n) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (seq_pending.size() > 0) begin
				nx = seq_pending.pop_front();
				ac_code_a <= nx.ac_a;
				ac_code_b <= nx.ac_b;
				ac_code_c <= nx.ac_c;
				dc_code_a <= nx.dc_a;
				dc_code_b <= nx.dc_b;
				in_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	int sink_gap = 0;
	always @(posedge clk) begin
		period_result_t e;
		if (out_valid && !out_stall) begin
			if (period_expected.size() == 0) begin
				$error("unexpected result transfer");
				fail_count++;
			end else begin
				e = period_expected.pop_front();
				if (ac_volts_avg !== e.ac_avg) begin
					$error("ac_volts_avg exp %0d got %0d", $signed(e.ac_avg), ac_volts_avg);
					fail_count++;
				end
				if (dc_volts_avg !== e.dc_avg) begin
					$error("dc_volts_avg exp %0d got %0d", e.dc_avg, dc_volts_avg);
					fail_count++;
				end
				if (polarity !== e.pol) begin
					$error("polarity exp %0d got %0d", e.pol, polarity);
					fail_count++;
				end
				if (switch_period !== e.period) begin
					$error("switch_period exp %0d got %0d", e.period, switch_period);
					fail_count++;
				end
				if (deadband_on !== e.db_on) begin
					$error("deadband_on exp %0d got %0d", e.db_on, deadband_on);
					fail_count++;
				end
			end
		end
		if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			out_stall <= 1'b1;
		end else if (!sink_quiet && $urandom_range(0, 9) < 3) begin
			sink_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(30, 300)
				: $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CMP: cmp_mirror = val[15:0];
			REG_PMAX: pmax_mirror = val[15:0];
			REG_PMIN: pmin_mirror = val[15:0];
			REG_THR: thr_mirror = val[14:0];
			REG_GAIN: gain_mirror = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int c, int pmx, int pmn, int thr, int g);
		write_reg(REG_CMP, c);
		write_reg(REG_PMAX, pmx);
		write_reg(REG_PMIN, pmn);
		write_reg(REG_THR, thr);
		write_reg(REG_GAIN, g);
	endtask

	task automatic push_seq(int a, int b, int c, int d, int e);
		seq_pending.push_back('{a[11:0], b[11:0], c[11:0], d[11:0], e[11:0]});
	endtask

	function automatic int near_code(int ctr, int spread);
		int x;
		x = ctr + $urandom_range(0, 2 * spread) - spread;
		return (x < 0) ? 0 : (x > 4095) ? 4095 : x;
	endfunction

	task automatic push_random(int n);
		int ac_c, dc_c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				ac_c = $urandom_range(0, 4095);
				dc_c = $urandom_range(0, 4095);
				push_seq(near_code(ac_c, 40), near_code(ac_c, 40), near_code(ac_c, 40),
					near_code(dc_c, 40), near_code(dc_c, 40));
			end else begin
				push_seq($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095));
			end
		end
	endtask

	task automatic drain();
		while (seq_pending.size() > 0 || in_valid || period_expected.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Startup with zero histories, rail extremes, zero crossing and each region.
		push_seq(0, 0, 0, 0, 0);
		push_seq(4095, 4095, 4095, 4095, 4095);
		push_seq(4095, 4095, 4095, 0, 0);
		push_seq(0, 0, 0, 4095, 4095);
		for (int i = 0; i < 5; i++)
			push_seq(2056, 2056, 2057, 0, 0);
		for (int i = 0; i < 5; i++)
			push_seq(2056, 2056, 2057, 3000, 3000);
		for (int i = 0; i < 5; i++)
			push_seq(3800, 3800, 3800, 1700, 1700);
		for (int i = 0; i < 5; i++)
			push_seq(300, 300, 300, 2300, 2300);
		drain();

		sender_quiet = 1'b1;
		sink_quiet = 1'b1;
		push_random(100);
		drain();
		sender_quiet = 1'b0;
		sink_quiet = 1'b0;
		push_random(250);
		drain();

		set_config(65535, 65535, 0, 32767, 65535);
		push_random(200);
		drain();
		set_config(0, 0, 65535, 0, 0);
		push_random(150);
		drain();
		set_config(60000, 40000, 100, 0, 65535);
		for (int i = 0; i < 10; i++)
			push_seq(3600, 3600, 3600, 1500, 1500);
		push_random(150);
		drain();
		for (int k = 0; k < 4; k++) begin
			set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 32767),
				$urandom_range(0, 65535));
			push_random(160);
			drain();
		end

		if (fail_count == 0)
			$display("pfc_switching_period_calc regression: pass");
		else
			$display("pfc_switching_period_calc regression: fail");
		$finish;
	end

	initial begin
		#80ms;
		$display("pfc_switching_period_calc regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pspc_pkg.sv
rtl/pspc_div.sv
rtl/pspc_sqrt.sv
rtl/pspc_datapath.sv
rtl/pspc_ctrl.sv
rtl/pfc_switching_period_calc.sv
verif/tb_pfc_switching_period_calc.sv
